// ----- rtl/sell_pkg.sv -----
package sell_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int LANE_W  = 2;
  localparam int CHUNK_W = 8;
  localparam int ROW_W   = 10;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 64;
  localparam int FRAC_W  = 16;
  // chunk times up to thirty-two lanes, plus the lane
  localparam int ROW_FULL_W = CHUNK_W + 5;
  localparam int PADDR_W = 3;

  localparam logic [LANE_W-1:0] CMD_LOAD_X = 2'd0;
  localparam logic [LANE_W-1:0] CMD_LOAD_Y = 2'd1;
  localparam logic [LANE_W-1:0] CMD_SLOT   = 2'd2;
  localparam logic [LANE_W-1:0] CMD_END    = 2'd3;

  // register index taken from the word address
  localparam logic REG_AXPY_MODE = 1'b0;

  typedef logic [1:0] cmd_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ACC_W:0] acc_wide_t;

  localparam acc_wide_t OUT_HI = {{(ACC_W-VALUE_W+2){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam acc_wide_t OUT_LO = {{(ACC_W-VALUE_W+2){1'b1}}, {(VALUE_W-1){1'b0}}};

  function automatic acc_t sat_acc(input acc_wide_t v);
    acc_t res;
    if (v[ACC_W] != v[ACC_W-1]) begin
      res = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic value_t sat_out(input acc_wide_t v);
    value_t res;
    if (v > OUT_HI) begin
      res = OUT_HI[VALUE_W-1:0];
    end else if (v < OUT_LO) begin
      res = OUT_LO[VALUE_W-1:0];
    end else begin
      res = v[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/sell_ram.sv -----
module sell_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sell_mac.sv -----
module sell_mac #(
  parameter int LANES        = 4,
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   x_we,
  input  logic                                   slot_en,
  input  logic [$clog2(VECTOR_DEPTH)-1:0]        addr,
  input  sell_pkg::value_t                       value,
  input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] lane,
  input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] sum_sel,
  output sell_pkg::acc_t                         sum_rd,
  input  logic                                   clr_en,
  input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] clr_lane
);

  import sell_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [VALUE_W-1:0]       x_rd;
  logic                     s1_valid_r;
  logic [LW-1:0]            s1_lane_r;
  value_t                   s1_value_r;
  logic                     p_valid_r;
  logic [LW-1:0]            p_lane_r;
  logic signed [PROD_W-1:0] prod_r;
  acc_t                     lane_sums_r [LANES];
  acc_t                     prod_q;

  sell_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (addr),
    .wdata (value),
    .re    (slot_en),
    .raddr (addr),
    .rdata (x_rd)
  );

  // floor of the Q32.32 product to Q32.16
  assign prod_q = prod_r[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= slot_en;
      p_valid_r  <= s1_valid_r;
    end
    s1_lane_r  <= lane;
    s1_value_r <= value;
    p_lane_r   <= s1_lane_r;
    prod_r     <= s1_value_r * $signed(x_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANES; k++) begin
        lane_sums_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < LANES; k++) begin
        if (clr_en && clr_lane == LW'(k)) begin
          lane_sums_r[k] <= '0;
        end else if (p_valid_r && p_lane_r == LW'(k)) begin
          lane_sums_r[k] <= sat_acc({lane_sums_r[k][ACC_W-1], lane_sums_r[k]} +
                                    {prod_q[ACC_W-1], prod_q});
        end
      end
    end
  end

  assign sum_rd = lane_sums_r[sum_sel];

endmodule

// ----- rtl/sell_emit.sv -----
module sell_emit #(
  parameter int LANES        = 4,
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [sell_pkg::CHUNK_W-1:0]           chunk,
  input  logic                                   axpy,
  input  logic                                   y_we,
  input  logic [$clog2(VECTOR_DEPTH)-1:0]        y_waddr,
  input  sell_pkg::value_t                       y_wdata,
  output logic                                   busy,
  output logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] sum_sel,
  input  sell_pkg::acc_t                         sum_rd,
  output logic                                   clr_en,
  output logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] clr_lane,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sell_pkg::ROW_W-1:0]             out_row,
  output sell_pkg::value_t                       out_y_value,
  output logic                                   out_last
);

  import sell_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CW = $clog2(LANES + 1);
  localparam int AW = $clog2(VECTOR_DEPTH);

  logic                  busy_r;
  logic [CHUNK_W-1:0]    chunk_r;
  logic [CW-1:0]         issue_cnt_r;
  logic                  e2_valid_r;
  logic [LW-1:0]         e2_lane_r;
  logic [ROW_FULL_W-1:0] e2_row_r;
  logic                  out_valid_r;
  logic [ROW_W-1:0]      out_row_r;
  value_t                out_y_value_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  e2_move;
  logic                  e2_last;
  logic                  issue;
  logic [ROW_FULL_W-1:0] row_issue;
  logic [VALUE_W-1:0]    y_rd;
  acc_wide_t             y_add;
  value_t                result;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  value_t                ram_wdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign e2_move   = e2_valid_r && out_free;
  assign e2_last   = (e2_lane_r == LW'(LANES - 1));
  assign issue     = busy_r && (issue_cnt_r < CW'(LANES)) && (!e2_valid_r || e2_move);
  assign row_issue = ROW_FULL_W'(chunk_r) * ROW_FULL_W'(LANES) + ROW_FULL_W'(issue_cnt_r);

  assign y_add  = axpy ? {{(ACC_W-VALUE_W+1){y_rd[VALUE_W-1]}}, y_rd} : '0;
  assign result = sat_out({sum_rd[ACC_W-1], sum_rd} + y_add);

  // the row write-back owns the port while a chunk drains; loads are stalled then
  assign ram_we    = y_we || e2_move;
  assign ram_waddr = e2_move ? AW'(e2_row_r) : y_waddr;
  assign ram_wdata = e2_move ? result : y_wdata;

  sell_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_y_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (AW'(row_issue)),
    .rdata (y_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      issue_cnt_r <= '0;
      e2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r      <= 1'b1;
        issue_cnt_r <= '0;
      end else begin
        if (e2_move && e2_last) begin
          busy_r <= 1'b0;
        end
        if (issue) begin
          issue_cnt_r <= issue_cnt_r + CW'(1);
        end
      end
      if (issue) begin
        e2_valid_r <= 1'b1;
      end else if (e2_move) begin
        e2_valid_r <= 1'b0;
      end
      if (e2_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (start) begin
      chunk_r <= chunk;
    end
    if (issue) begin
      e2_lane_r <= LW'(issue_cnt_r);
      e2_row_r  <= row_issue;
    end
    if (e2_move) begin
      out_row_r     <= ROW_W'(e2_row_r);
      out_y_value_r <= result;
      out_last_r    <= e2_last;
    end
  end

  assign busy        = busy_r;
  assign sum_sel     = e2_lane_r;
  assign clr_en      = e2_move;
  assign clr_lane    = e2_lane_r;
  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_y_value = out_y_value_r;
  assign out_last    = out_last_r;

endmodule

// ----- rtl/sliced_ell_spmv_accumulate.sv -----
// Loads and matrix slots are taken one beat per cycle while in_stall is low; a slot's
// product reaches its lane accumulator through the x memory read at the accepting edge,
// then the product register, then the add.
// An end-chunk beat stalls the input while the y memory is read and written back one lane
// a cycle; results leave through the y read stage and the output register, one per cycle
// unless out_stall holds them. VECTOR_DEPTH must be a power of two; the block does not check it.
// Synchronous active-low reset clears the accumulators, axpy_mode and all control.
module sliced_ell_spmv_accumulate #(
  parameter int LANES        = 4,
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sell_pkg::cmd_t                  in_cmd,
  input  logic [sell_pkg::INDEX_W-1:0]    in_index,
  input  logic [sell_pkg::LANE_W-1:0]     in_lane,
  input  sell_pkg::value_t                in_value,
  input  logic [sell_pkg::CHUNK_W-1:0]    in_chunk,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sell_pkg::ROW_W-1:0]      out_row,
  output sell_pkg::value_t                out_y_value,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sell_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import sell_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int AW = $clog2(VECTOR_DEPTH);

  logic          axpy_r;
  logic          accept;
  logic          lane_ok;
  logic          busy;
  logic [LW-1:0] sum_sel;
  acc_t          sum_rd;
  logic          clr_en;
  logic [LW-1:0] clr_lane;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_AXPY_MODE);
  assign prdata  = (paddr[2] == REG_AXPY_MODE) ? {31'd0, axpy_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axpy_r <= 1'b0;
    end else if (cfg_wr) begin
      axpy_r <= pwdata[0];
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  // drop slots for lanes the block does not have
  assign lane_ok  = int'(in_lane) < LANES;

  sell_mac #(
    .LANES        (LANES),
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .x_we     (accept && in_cmd == CMD_LOAD_X),
    .slot_en  (accept && in_cmd == CMD_SLOT && lane_ok),
    .addr     (AW'(in_index)),
    .value    (in_value),
    .lane     (LW'(in_lane)),
    .sum_sel  (sum_sel),
    .sum_rd   (sum_rd),
    .clr_en   (clr_en),
    .clr_lane (clr_lane)
  );

  sell_emit #(
    .LANES        (LANES),
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept && in_cmd == CMD_END),
    .chunk       (in_chunk),
    .axpy        (axpy_r),
    .y_we        (accept && in_cmd == CMD_LOAD_Y),
    .y_waddr     (AW'(in_index)),
    .y_wdata     (in_value),
    .busy        (busy),
    .sum_sel     (sum_sel),
    .sum_rd      (sum_rd),
    .clr_en      (clr_en),
    .clr_lane    (clr_lane),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_y_value (out_y_value),
    .out_last    (out_last)
  );

endmodule

// ----- tb/sv/sliced_ell_spmv_accumulate_test.sv -----
module sliced_ell_spmv_accumulate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sell_pkg::*;

  localparam int LANES = 4;
  localparam int VECTOR_DEPTH = 1024;
  localparam int RANDOM_BEATS = 450;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [PADDR_W-1:0] AXPY_ADDR = {REG_AXPY_MODE, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {~REG_AXPY_MODE, 2'b00};

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint Y_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Y_LO = -Y_HI - 1;

  localparam value_t Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    value_t           y_value;
    logic             last;
  } row_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HOLD} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cmd_t                in_cmd = CMD_LOAD_X;
  logic [INDEX_W-1:0]  in_index = '0;
  logic [LANE_W-1:0]   in_lane = '0;
  value_t              in_value = '0;
  logic [CHUNK_W-1:0]  in_chunk = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ROW_W-1:0]    out_row;
  value_t              out_y_value;
  logic                out_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  value_t      x_mem [VECTOR_DEPTH];
  value_t      y_mem [VECTOR_DEPTH];
  acc_t        lane_sum [LANES];
  logic        axpy_on = 1'b0;
  bit          x_seen [VECTOR_DEPTH];
  bit          y_seen [VECTOR_DEPTH];
  int          x_written [$];
  row_result_t pending_rows [$];

  int  fail_count = 0;
  int  beats_sent = 0;
  int  rows_checked = 0;
  int  chunks_closed = 0;
  int  acc_clamps = 0;
  int  y_clamps = 0;
  int  settings_run = 0;
  int  burst_left = 0;
  bit  steady = 1'b0;
  int  cycle_count = 0;
  int  stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  sliced_ell_spmv_accumulate #(
    .LANES(LANES),
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_index(in_index),
    .in_lane(in_lane),
    .in_value(in_value),
    .in_chunk(in_chunk),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row(out_row),
    .out_y_value(out_y_value),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver back-pressure: free runs, coin flips, a fixed pattern and solid holds
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_RANDOM:  out_stall <= 1'($urandom_range(0, 1));
      STALL_PATTERN: out_stall <= (stall_left % 3 != 0);
      default:       out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        $error("result beat with nothing expected: row %0d y_value %0h", out_row, out_y_value);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, out_row);
          fail_count++;
        end
        if (out_y_value !== want.y_value) begin
          $error("y_value: expected %0h, got %0h", want.y_value, out_y_value);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void predict_beat(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                                       input logic [LANE_W-1:0] lane, input value_t val,
                                       input logic [CHUNK_W-1:0] chunk);
    longint prod;
    longint sum;
    int row_i;
    int addr;
    row_result_t res;
    case (cmd)
      CMD_LOAD_X: begin
        x_mem[idx] = val;
        if (!x_seen[idx]) begin
          x_seen[idx] = 1'b1;
          x_written.push_back(int'(idx));
        end
      end
      CMD_LOAD_Y: begin
        y_mem[idx] = val;
        y_seen[idx] = 1'b1;
      end
      CMD_SLOT: begin
        if (lane < LANES) begin
          // exact Q32.32 product, floored to Q32.16
          prod = (longint'(val) * longint'(x_mem[idx])) >>> FRAC_W;
          sum = longint'(lane_sum[lane]) + prod;
          if (sum != clamp_to(sum, ACC_LO, ACC_HI)) acc_clamps++;
          lane_sum[lane] = acc_t'(clamp_to(sum, ACC_LO, ACC_HI));
        end
      end
      default: begin
        for (int k = 0; k < LANES; k++) begin
          row_i = int'(chunk) * LANES + k;
          addr = row_i % VECTOR_DEPTH;
          sum = longint'(lane_sum[k]);
          if (axpy_on) sum += longint'(y_mem[addr]);
          if (sum != clamp_to(sum, Y_LO, Y_HI)) y_clamps++;
          sum = clamp_to(sum, Y_LO, Y_HI);
          y_mem[addr] = value_t'(sum);
          y_seen[addr] = 1'b1;
          res.row = row_i[ROW_W-1:0];
          res.y_value = value_t'(sum);
          res.last = (k == LANES - 1);
          pending_rows.push_back(res);
          lane_sum[k] = '0;
        end
        chunks_closed++;
      end
    endcase
  endfunction

  function automatic value_t pick_q16();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3:    return value_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      4:       return value_t'(int'($urandom_range(0, 6)) - 3);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                           input logic [LANE_W-1:0] lane, input value_t val,
                           input logic [CHUNK_W-1:0] chunk);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_index <= idx;
    in_lane <= lane;
    in_value <= val;
    in_chunk <= chunk;
    do @(posedge clk); while (in_stall);
    predict_beat(cmd, idx, lane, val, chunk);
    beats_sent++;
  endtask

  // drop valid, let every expected row arrive, then let in-flight slots land
  task automatic drain_and_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AXPY_ADDR) axpy_on = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AXPY_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, axpy_on}) begin
      $error("axpy_mode readback: expected %0h, got %0h", {31'b0, axpy_on}, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_access();
    reg_check();
    // a write to the unused word must leave axpy_mode alone
    reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    reg_check();
  endtask

  task automatic test_fixed_point_extremes();
    reg_write(AXPY_ADDR, 32'h0000_0000);
    send_beat(CMD_LOAD_X, 10'd0, 2'd0, Q_MIN, 8'd0);
    send_beat(CMD_LOAD_X, 10'd1023, 2'd3, Q_MAX, 8'd255);
    send_beat(CMD_LOAD_X, 10'd5, 2'd0, Q_ONE, 8'd0);
    send_beat(CMD_LOAD_X, 10'd6, 2'd0, 32'sd1, 8'd0);
    // lane 0 overflows the accumulator upwards; lane 1 ends just above its lower bound
    repeat (3) send_beat(CMD_SLOT, 10'd0, 2'd0, Q_MIN, 8'd0);
    repeat (2) send_beat(CMD_SLOT, 10'd0, 2'd1, Q_MAX, 8'd0);
    // minus one LSB times one LSB floors to minus one
    send_beat(CMD_SLOT, 10'd6, 2'd2, -32'sd1, 8'd0);
    send_beat(CMD_SLOT, 10'd5, 2'd3, 32'sh0002_8000, 8'd0);
    send_beat(CMD_END, 10'd0, 2'd0, 32'sd0, 8'd255);
    // nothing accumulated: all zeros
    send_beat(CMD_END, 10'd1023, 2'd3, Q_MAX, 8'd0);
    drain_and_wait();
  endtask

  task automatic test_axpy_directed();
    reg_write(AXPY_ADDR, 32'hFFFF_FFFF);
    reg_check();
    send_beat(CMD_LOAD_Y, 10'd0, 2'd0, Q_MAX, 8'd0);
    send_beat(CMD_LOAD_Y, 10'd1, 2'd0, Q_MIN, 8'd0);
    send_beat(CMD_SLOT, 10'd5, 2'd0, Q_ONE, 8'd0);
    send_beat(CMD_SLOT, 10'd5, 2'd1, -Q_ONE, 8'd0);
    send_beat(CMD_SLOT, 10'd1023, 2'd3, Q_MAX, 8'd0);
    send_beat(CMD_END, 10'd0, 2'd0, 32'sd0, 8'd0);
    // empty chunk in axpy mode returns the stored rows
    send_beat(CMD_END, 10'd0, 2'd0, 32'sd0, 8'd255);
    drain_and_wait();
    settings_run += 2;
  endtask

  task automatic send_chunk_sequence();
    int n_slot;
    int row_a;
    logic [INDEX_W-1:0] col;
    logic [CHUNK_W-1:0] chunk;
    repeat ($urandom_range(0, 3))
      send_beat(CMD_LOAD_X, INDEX_W'($urandom_range(0, VECTOR_DEPTH - 1)), LANE_W'($urandom),
                pick_q16(), CHUNK_W'($urandom));
    n_slot = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
    for (int k = 0; k < n_slot; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat($urandom_range(0, 1) ? CMD_LOAD_Y : CMD_LOAD_X,
                  INDEX_W'($urandom_range(0, VECTOR_DEPTH - 1)), LANE_W'($urandom),
                  pick_q16(), CHUNK_W'($urandom));
      col = INDEX_W'(x_written[$urandom_range(0, x_written.size() - 1)]);
      send_beat(CMD_SLOT, col, LANE_W'($urandom_range(0, LANES - 1)), pick_q16(),
                CHUNK_W'($urandom));
    end
    // leave some chunks open so their sums carry into the next one
    if ($urandom_range(0, 5) == 0) return;
    case ($urandom_range(0, 7))
      0:       chunk = '0;
      1:       chunk = '1;
      default: chunk = CHUNK_W'($urandom);
    endcase
    if (axpy_on) begin
      for (int k = 0; k < LANES; k++) begin
        row_a = (int'(chunk) * LANES + k) % VECTOR_DEPTH;
        if (!y_seen[row_a] || $urandom_range(0, 3) == 0)
          send_beat(CMD_LOAD_Y, INDEX_W'(row_a), LANE_W'($urandom), pick_q16(),
                    CHUNK_W'($urandom));
      end
    end
    send_beat(CMD_END, INDEX_W'($urandom), LANE_W'($urandom), value_t'($urandom), chunk);
  endtask

  task automatic test_random_chunks();
    int start;
    int phase_start;
    int phase_len;
    logic [31:0] mode_word;
    start = beats_sent;
    for (int phase = 0; beats_sent - start < RANDOM_BEATS; phase++) begin
      drain_and_wait();
      mode_word = $urandom;
      mode_word[0] = phase[0];
      reg_write(AXPY_ADDR, mode_word);
      reg_check();
      settings_run++;
      steady = (phase % 3 == 2);
      phase_start = beats_sent;
      phase_len = $urandom_range(60, 120);
      while (beats_sent - phase_start < phase_len && beats_sent - start < RANDOM_BEATS)
        send_chunk_sequence();
    end
    steady = 1'b0;
    drain_and_wait();
  endtask

  initial begin
    foreach (lane_sum[k]) lane_sum[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_fixed_point_extremes();
    test_axpy_directed();
    test_random_chunks();
    $display("Sent %0d beats over %0d register settings; %0d chunks closed, %0d rows checked.",
             beats_sent, settings_run, chunks_closed, rows_checked);
    $display("Accumulator clamps: %0d, output clamps: %0d.", acc_clamps, y_clamps);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
